[design/tcor_pkg.sv]
// shared types and constants for the thick circle outline rasterizer
// no dependencies; imported by every module of the block
package tcor_pkg;

  localparam int unsigned OUT_W   = 16;  // width of every rectangle coordinate
  localparam int unsigned THICK_W = 8;   // width of the square side
  localparam int unsigned RECTS   = 4;   // rectangles per producing item
  localparam int unsigned IDX_W   = 2;   // index into the rectangles of one item

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] top;
    logic signed [OUT_W-1:0] right_end;
    logic signed [OUT_W-1:0] bottom_end;
    logic                    last;
    logic                    done_res;
  } rect_t;

endpackage

[design/thick_circle_outline_rasterizer.sv]
// top level of the thick circle outline rasterizer: input register, walk, result buffer
// depends on tcor_pkg, tcor_walk, tcor_obuf
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: center_x, center_y, radius, thickness
//                                            tuser: op (0 start, 1 step)
// m_axis    out  m_axis_tvalid/tready        tdata: left, top, right_end, bottom_end
//                                            tlast: last, tuser: done_res
//
// a start, or a step while a circle is active, yields four rectangles, one per cycle
// on the result channel while it is ready; the single output channel behind the
// four-entry result buffer sets the item rate; it refills as its last rectangle leaves
// a step while idle yields nothing and leaves without waiting for the result buffer
// the first rectangle leaves from the result buffer, loaded from the input register
// reset clears the walk (idle, side 1) and empties both registers
// a stalled result channel holds the buffer; the input register keeps accepting
// until it holds an item that still waits for the buffer
module thick_circle_outline_rasterizer import tcor_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 15,
  parameter int unsigned RADIUS_WIDTH = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // center_x, center_y, radius, thickness from bit 0 up, zero padded
  input  logic [((2*COORD_WIDTH+RADIUS_WIDTH+THICK_W+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // left, top, right_end, bottom_end from bit 0 up
  output logic [4*OUT_W-1:0]   m_axis_tdata_o,
  output logic                 m_axis_tlast_o,
  // done_res
  output logic                 m_axis_tuser_o
);

  localparam int unsigned CY_LO = COORD_WIDTH;
  localparam int unsigned R_LO  = 2 * COORD_WIDTH;
  localparam int unsigned TH_LO = 2 * COORD_WIDTH + RADIUS_WIDTH;

  // input register
  logic                          in_valid_q;
  op_e                           in_op_q;
  logic signed [COORD_WIDTH-1:0] in_cx_q, in_cy_q;
  logic [RADIUS_WIDTH-1:0]       in_r_q;
  logic [THICK_W-1:0]            in_th_q;

  logic              s_xfer, consume, load, emit, buf_free;
  rect_t [RECTS-1:0] rects;
  rect_t             rect_out;

  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  // an item leaves the input register when it yields nothing or the buffer frees up
  assign consume         = in_valid_q && (!emit || buf_free);
  assign load            = in_valid_q && emit && buf_free;
  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_op_q <= op_e'(s_axis_tuser_i);
      in_cx_q <= s_axis_tdata_i[CY_LO-1:0];
      in_cy_q <= s_axis_tdata_i[R_LO-1:CY_LO];
      in_r_q  <= s_axis_tdata_i[TH_LO-1:R_LO];
      in_th_q <= s_axis_tdata_i[TH_LO+THICK_W-1:TH_LO];
    end
  end

  // walk state and rectangle geometry, updated when the item is consumed
  tcor_walk #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (consume),
    .op_i    (in_op_q),
    .cx_i    (in_cx_q),
    .cy_i    (in_cy_q),
    .r_i     (in_r_q),
    .thick_i (in_th_q),
    .rects_o (rects),
    .emit_o  (emit)
  );

  // four rectangles out, one transfer each
  tcor_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .rects_i   (rects),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .rect_o    (rect_out),
    .free_o    (buf_free)
  );

  assign m_axis_tdata_o = {rect_out.bottom_end, rect_out.right_end,
                           rect_out.top, rect_out.left};
  assign m_axis_tlast_o = rect_out.last;
  assign m_axis_tuser_o = rect_out.done_res;

  // an item is accepted only into a register that is empty or draining
  a_in_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && in_valid_q) |-> consume)
    else $error("input register overwritten");

endmodule

[design/tcor_walk.sv]
// circle walk state and the geometry of the four rectangles of one item
// depends on tcor_pkg
module tcor_walk import tcor_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 15,
  parameter int unsigned RADIUS_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  op_e                           op_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic [RADIUS_WIDTH-1:0]       r_i,
  input  logic [THICK_W-1:0]            thick_i,
  output rect_t [RECTS-1:0]             rects_o,
  output logic                          emit_o
);

  localparam int unsigned WW = RADIUS_WIDTH + 1;
  localparam int unsigned EW = RADIUS_WIDTH + 4;
  localparam int unsigned M1 = (COORD_WIDTH > WW) ? COORD_WIDTH : WW;
  localparam int unsigned M2 = (M1 > THICK_W + 1) ? M1 : THICK_W + 1;
  localparam int unsigned PW = M2 + 2;

  localparam logic signed [EW-1:0] ONE_E  = EW'(1);
  localparam logic signed [EW-1:0] TWO_E  = EW'(2);
  localparam logic signed [EW-1:0] ZERO_E = '0;

  logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
  logic signed [WW-1:0]          x_q, y_q;
  logic signed [EW-1:0]          d_q;
  logic [THICK_W-1:0]            side_q;
  logic                          active_q;

  logic                 is_start;
  logic [THICK_W-1:0]   side_in, side_sel;
  logic signed [PW-1:0] cx_w, cy_w, dx_w, dy_w;
  logic signed [PW-1:0] col_pos, col_neg, row_pos, row_neg;
  logic signed [EW-1:0] xe, ye, re, y1, d1, x1, d2, d0;
  logic                 dec_y, inc_x, done_step, done_start;

  function automatic rect_t square(input logic signed [PW-1:0] px,
                                   input logic signed [PW-1:0] py,
                                   input logic [THICK_W-1:0]   side);
    logic signed [PW-1:0] half, rest, l, t;
    rect_t                rc;
    half = signed'(PW'(side >> 1));
    rest = signed'(PW'(side)) - half;
    l    = px - half;
    t    = py - half;
    if (l < 0) l = '0;
    if (t < 0) t = '0;
    rc.left       = OUT_W'(l);
    rc.top        = OUT_W'(t);
    rc.right_end  = OUT_W'(px + rest);
    rc.bottom_end = OUT_W'(py + rest);
    rc.last       = 1'b0;
    rc.done_res   = 1'b0;
    return rc;
  endfunction

  function automatic rect_t pixel(input logic signed [PW-1:0] px,
                                  input logic signed [PW-1:0] py);
    rect_t rc;
    rc.left       = OUT_W'(px);
    rc.top        = OUT_W'(py);
    rc.right_end  = OUT_W'(px + PW'(1));
    rc.bottom_end = OUT_W'(py + PW'(1));
    rc.last       = 1'b0;
    rc.done_res   = 1'b0;
    return rc;
  endfunction

  assign is_start = (op_i == OP_START);
  assign side_in  = (thick_i == '0) ? THICK_W'(1) : thick_i;
  assign side_sel = is_start ? side_in : side_q;

  // start: offsets (r, 0); step: offsets (x, y)
  assign cx_w = is_start ? PW'(cx_i) : PW'(cx_q);
  assign cy_w = is_start ? PW'(cy_i) : PW'(cy_q);
  assign dx_w = is_start ? signed'(PW'(r_i)) : PW'(x_q);
  assign dy_w = is_start ? '0 : PW'(y_q);

  assign col_pos = cx_w + dx_w;
  assign col_neg = cx_w - dx_w;
  assign row_pos = cy_w + dy_w;
  assign row_neg = cy_w - dy_w;

  // error walk
  assign xe    = EW'(x_q);
  assign ye    = EW'(y_q);
  assign dec_y = (d_q + ye) > ZERO_E;
  assign y1    = dec_y ? ye - ONE_E : ye;
  assign d1    = dec_y ? d_q - ((y1 <<< 1) - ONE_E) : d_q;
  assign inc_x = xe > d1;
  assign x1    = inc_x ? xe + ONE_E : xe;
  assign d2    = inc_x ? d1 + (x1 <<< 1) + ONE_E : d1;
  assign done_step = !(y1 > ZERO_E);

  assign re         = signed'(EW'(r_i));
  assign d0         = TWO_E - (re <<< 1);
  assign done_start = (r_i == '0);

  always_comb begin
    if (is_start) begin
      rects_o[0] = pixel(col_pos, row_pos);
      rects_o[1] = square(col_pos, row_neg, side_sel);
      rects_o[2] = pixel(col_neg, row_pos);
    end else begin
      rects_o[0] = square(col_pos, row_pos, side_sel);
      rects_o[1] = square(col_pos, row_neg, side_sel);
      rects_o[2] = square(col_neg, row_pos, side_sel);
    end
    rects_o[3]          = square(col_neg, row_neg, side_sel);
    rects_o[3].last     = 1'b1;
    rects_o[3].done_res = is_start ? done_start : done_step;
  end

  assign emit_o = is_start || active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
      side_q   <= THICK_W'(1);
      active_q <= 1'b0;
    end else if (upd_i) begin
      if (is_start) begin
        cx_q     <= cx_i;
        cy_q     <= cy_i;
        side_q   <= side_in;
        x_q      <= '0;
        y_q      <= signed'(WW'(r_i));
        d_q      <= d0;
        active_q <= !done_start;
      end else if (active_q) begin
        x_q      <= WW'(x1);
        y_q      <= WW'(y1);
        d_q      <= d2;
        active_q <= !done_step;
      end
    end
  end

  // walk runs only while rows remain
  a_active_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (y_q > 0))
    else $error("walk active with no rows left");

  // a step while idle leaves the walk untouched
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && op_i == OP_STEP && !active_q) |=>
      ($stable(x_q) && $stable(y_q) && $stable(d_q) && !active_q))
    else $error("idle step changed walk state");

endmodule

[design/tcor_obuf.sv]
// result buffer: holds the four rectangles of one item and sends them in order
// depends on tcor_pkg
module tcor_obuf import tcor_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rect_t [RECTS-1:0] rects_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output rect_t             rect_o,
  output logic              free_o
);

  rect_t [RECTS-1:0] buf_q;
  logic              valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic              take, last_take;

  assign take      = valid_q && m_ready_i;
  assign last_take = take && (idx_q == IDX_W'(RECTS - 1));
  assign free_o    = !valid_q || last_take;
  assign m_valid_o = valid_q;
  assign rect_o    = buf_q[idx_q];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= rects_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (last_take) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (take) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result buffer loaded while rectangles pending");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rect_o.done_res) |-> rect_o.last)
    else $error("done flag on a rectangle that is not last");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_take && !load_i) |=> (!valid_q && idx_q == '0))
    else $error("buffer not empty after final transfer");

endmodule

[test/tb_top.sv]
// self-checking bench for the thick circle outline rasterizer: directed and random
// circles pass through the stream ports; rectangles are checked against a local walk
// depends on tcor_pkg and thick_circle_outline_rasterizer
`timescale 1ns / 100ps

module tb_top;
  import tcor_pkg::*;

  localparam int CW     = 15;
  localparam int RW     = 12;
  localparam int DATA_W = ((2*CW+RW+THICK_W+7)/8)*8;
  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int TARGET_ITEMS = 380;  // approximate input items over the whole run
  localparam int DRAIN_CYCLES = 20;

  // one input item as the block sees it
  typedef struct packed {
    op_e                     op;
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic [RW-1:0]           radius;
    logic [THICK_W-1:0]      thick;
  } circle_item_t;

  // walk state of one circle
  typedef struct {
    int col;
    int row;
    int wx;
    int wy;
    int err;
    int side;
    bit busy;
  } walk_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_valid;
  logic              s_ready;
  logic [DATA_W-1:0] s_data;
  logic              s_user;
  logic              m_valid;
  logic              m_ready;
  logic [4*OUT_W-1:0] m_data;
  logic              m_last;
  logic              m_user;

  thick_circle_outline_rasterizer #(
    .COORD_WIDTH (CW),
    .RADIUS_WIDTH(RW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user)
  );

  circle_item_t pending_items[$];   // items waiting for the driver
  rect_t        expected_rects[$];  // rectangles predicted, not yet seen
  walk_t        dut_walk;           // walk state tracked at input transfers
  walk_t        gen_walk;           // walk state tracked while generating
  circle_item_t cur_item;
  rect_t        drv_rects[4];
  int           drv_count;
  int           items_queued;
  int           items_sent;
  int           failures;
  int           quiet_cycles;
  int           send_idle_pct;
  int           stall_pct;

  function automatic walk_t reset_walk();
    walk_t w;
    w.col  = 0;
    w.row  = 0;
    w.wx   = 0;
    w.wy   = 0;
    w.err  = 0;
    w.side = 1;
    w.busy = 1'b0;
    return w;
  endfunction

  function automatic rect_t make_rect(int l, int t, int r, int b, bit last, bit done);
    rect_t rc;
    rc.left       = OUT_W'(l);
    rc.top        = OUT_W'(t);
    rc.right_end  = OUT_W'(r);
    rc.bottom_end = OUT_W'(b);
    rc.last       = last;
    rc.done_res   = done;
    return rc;
  endfunction

  // centered square: even sides reach one further left and up, near edges clamp at 0
  function automatic rect_t make_square(int side, int px, int py, bit last, bit done);
    int half;
    int rest;
    int l;
    int t;
    half = side / 2;
    rest = side - half;
    l = px - half;
    t = py - half;
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    return make_rect(l, t, px + rest, py + rest, last, done);
  endfunction

  // advances the walk by one item and returns how many rectangles it yields
  function automatic int trace_circle(inout walk_t w, input circle_item_t it,
                                      output rect_t rects[4]);
    int  r;
    int  x;
    int  y;
    bit  done;
    if (it.op == OP_START) begin
      r      = int'(it.radius);
      w.col  = int'(it.cx);
      w.row  = int'(it.cy);
      w.side = (it.thick < 1) ? 1 : int'(it.thick);
      w.wx   = 0;
      w.wy   = r;
      w.err  = 2 * (1 - r);
      done   = (r == 0);
      w.busy = !done;
      // single pixels are never clamped
      rects[0] = make_rect(w.col + r, w.row, w.col + r + 1, w.row + 1, 1'b0, 1'b0);
      rects[1] = make_square(w.side, w.col + r, w.row, 1'b0, 1'b0);
      rects[2] = make_rect(w.col - r, w.row, w.col - r + 1, w.row + 1, 1'b0, 1'b0);
      rects[3] = make_square(w.side, w.col - r, w.row, 1'b1, done);
      return 4;
    end
    // a step with no circle loaded is ignored
    if (!w.busy) return 0;
    x = w.wx;
    y = w.wy;
    rects[0] = make_square(w.side, w.col + x, w.row + y, 1'b0, 1'b0);
    rects[1] = make_square(w.side, w.col + x, w.row - y, 1'b0, 1'b0);
    rects[2] = make_square(w.side, w.col - x, w.row + y, 1'b0, 1'b0);
    if (w.err + w.wy > 0) begin
      w.wy  = w.wy - 1;
      w.err = w.err - (2 * w.wy - 1);
    end
    if (w.wx > w.err) begin
      w.wx  = w.wx + 1;
      w.err = w.err + 2 * w.wx + 1;
    end
    done = (w.wy <= 0);
    if (done) w.busy = 1'b0;
    rects[3] = make_square(w.side, w.col - x, w.row - y, 1'b1, done);
    return 4;
  endfunction

  // queues one item and keeps the generator's view of the walk current
  task automatic queue_item(op_e op, int cx, int cy, int radius, int thick);
    circle_item_t it;
    rect_t        scratch[4];
    it.op     = op;
    it.cx     = CW'(cx);
    it.cy     = CW'(cy);
    it.radius = RW'(radius);
    it.thick  = THICK_W'(thick);
    pending_items.push_back(it);
    items_queued++;
    void'(trace_circle(gen_walk, it, scratch));
  endtask

  // step items carry random payload bits that the block must ignore
  task automatic queue_step();
    queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic finish_walk();
    while (gen_walk.busy) queue_step();
  endtask

  // holds the sender back until every transfer is through and every result is in
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_sent != items_queued || expected_rects.size() != 0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver: presents queued items, holds them until transfer, predicts on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= OP_START;
    end else begin
      if (s_valid && s_ready) begin
        drv_count = trace_circle(dut_walk, cur_item, drv_rects);
        for (int i = 0; i < drv_count; i++) expected_rects.push_back(drv_rects[i]);
        items_sent++;
      end
      if (!s_valid || s_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          s_valid <= 1'b1;
          s_data  <= DATA_W'({cur_item.thick, cur_item.radius, cur_item.cy, cur_item.cx});
          s_user  <= cur_item.op;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each rectangle transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_rects.size() == 0) begin
          $error("rectangle (%0d,%0d)-(%0d,%0d) with nothing expected",
                 $signed(m_data[15:0]), $signed(m_data[31:16]),
                 $signed(m_data[47:32]), $signed(m_data[63:48]));
          failures++;
        end else begin
          check_field("left", int'(expected_rects[0].left), int'($signed(m_data[15:0])));
          check_field("top", int'(expected_rects[0].top), int'($signed(m_data[31:16])));
          check_field("right_end", int'(expected_rects[0].right_end),
                      int'($signed(m_data[47:32])));
          check_field("bottom_end", int'(expected_rects[0].bottom_end),
                      int'($signed(m_data[63:48])));
          check_field("last", int'(expected_rects[0].last), int'(m_last));
          check_field("done_res", int'(expected_rects[0].done_res), int'(m_user));
          void'(expected_rects.pop_front());
        end
      end
      m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: too long without any transfer on either side means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int rad;
    int cx;
    int cy;
    int th;
    int target;
    int base;
    dut_walk        = reset_walk();
    gen_walk        = reset_walk();
    items_queued    = 0;
    items_sent      = 0;
    failures        = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle step with all payload bits set
    queue_item(OP_STEP, -1, -1, 4095, 255);
    // zero radius with thickness 0 taken as 1, then an idle step again
    queue_item(OP_START, 0, 0, 0, 0);
    queue_step();
    // largest radius and side at the field extremes, dropped by a new start
    queue_item(OP_START, 16383, -16384, 4095, 255);
    queue_step();
    queue_step();
    // start while active, even side, other corner of the coordinate range
    queue_item(OP_START, -16384, 16383, 3, 2);
    finish_walk();
    // all payload bits set on a start
    queue_item(OP_START, -1, -1, 4095, 255);
    queue_step();
    // squares wholly left of and above 0 give empty rectangles
    queue_item(OP_START, -200, -150, 5, 9);
    finish_walk();
    // clamping near the origin with a wide side
    queue_item(OP_START, 1, 0, 2, 200);
    finish_walk();
    queue_item(OP_START, 40, 30, 1, 1);
    finish_walk();
    queue_step();

    // random part in four idling phases; each phase ends with a full drain
    base   = items_queued;
    target = base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      target += (TARGET_ITEMS - base) / 4;
      while (items_queued < target) begin
        th = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 1) begin
          cx = $urandom_range(0, 2**CW - 1);
          cy = $urandom_range(0, 2**CW - 1);
        end else begin
          cx = $urandom_range(0, 80) - 40;
          cy = $urandom_range(0, 80) - 40;
        end
        if ($urandom_range(0, 99) < 82) begin
          // complete circle: mostly small radii so walks stay short
          case ($urandom_range(0, 19))
            0:       rad = $urandom_range(25, 60);
            1, 2, 3, 4, 5, 6: rad = $urandom_range(7, 24);
            default: rad = $urandom_range(0, 6);
          endcase
          queue_item(OP_START, cx, cy, rad, th);
          finish_walk();
          if ($urandom_range(0, 4) == 0) queue_step();
        end else if ($urandom_range(0, 1) == 1) begin
          // abandoned circle with any radius, cut short by the next start
          queue_item(OP_START, cx, cy, $urandom_range(0, 2**RW - 1), th);
          repeat ($urandom_range(0, 6)) queue_step();
        end else begin
          repeat ($urandom_range(1, 3)) queue_step();
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[thick_circle_outline_rasterizer.f]
design/tcor_pkg.sv
design/tcor_walk.sv
design/tcor_obuf.sv
design/thick_circle_outline_rasterizer.sv
test/tb_top.sv
